/* rtl/core/usb_packet_tx_queue_core_assert.svh */
// Assertion macros used by the packet transmit queue sequencer.
// Expects clk and rst in the including module's scope.
`ifndef USB_PACKET_TX_QUEUE_CORE_ASSERT_SVH
`define USB_PACKET_TX_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold on every clock edge out of reset.
`define UPTQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger in one cycle implies consequence in the next.
`define UPTQ_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`else

`define UPTQ_ASSERT_ALWAYS(label, cond, msg)
`define UPTQ_ASSERT_NEXT(label, trig, cons, msg)

`endif

`endif

/* rtl/core/uptq_pkg.sv */
// Package for the packet transmit queue: sizes, codes, payload and status types.
// No dependencies.
`timescale 1ns / 1ps

package uptq_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int SLOT_COUNT   = 16;
  localparam int STORE_BYTES  = PACKET_BYTES * SLOT_COUNT;

  localparam int POS_W  = $clog2(PACKET_BYTES);
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int ADDR_W = $clog2(STORE_BYTES);

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(PACKET_BYTES - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  localparam logic [7:0] MARK_START  = 8'h3F;  // '?'
  localparam logic [7:0] MARK_HEADER = 8'h23;  // '#'

  // Index of the final byte pushed by each append or header op
  localparam logic [2:0] APPEND_LAST_IDX = 3'd0;
  localparam logic [2:0] HEADER_LAST_IDX = 3'd7;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_HEADER = 2'd1,
    OP_PAD    = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_PAD,
    ST_RD,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic [15:0] message_id;
    logic [31:0] message_length;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic        empty_res;
    logic [31:0] drop_count;
  } res_t;

  // Read-side status from the sequencer to the result stage
  typedef struct packed {
    logic        rd_pend;
    logic        rd_last;
    logic        empty_pend;
    logic [31:0] drops;
  } rd_status_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [POS_W-1:0]  pos);
    return ADDR_W'(slot * PACKET_BYTES) + ADDR_W'(pos);
  endfunction

endpackage

/* rtl/core/uptq_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module uptq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/uptq_ctrl.sv */
// Sequencer for the packet queue: ring pointers, fill position, drop count,
// and all store accesses. Depends on uptq_pkg and the assertion header.
`timescale 1ns / 1ps

module uptq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  uptq_pkg::cmd_t            cmd,
  output logic                      busy,
  output logic                      mem_we,
  output logic [uptq_pkg::ADDR_W-1:0] mem_waddr,
  output logic [7:0]                mem_wdata,
  output logic                      mem_re,
  output logic [uptq_pkg::ADDR_W-1:0] mem_raddr,
  output uptq_pkg::rd_status_t      status
);

  import uptq_pkg::*;

  `include "usb_packet_tx_queue_core_assert.svh"

  state_t            state;
  state_t            state_next;
  cmd_t              c;
  logic [2:0]        k;
  logic [POS_W-1:0]  fill;
  logic [POS_W-1:0]  rpos;
  logic [SLOT_W-1:0] read_slot;
  logic [SLOT_W-1:0] write_slot;
  logic [31:0]       drops;
  logic              rd_pend;
  logic              rd_last;
  logic              empty_pend;
  logic [7:0]        push_val;
  logic [2:0]        push_last_idx;
  logic              opening;

  assign opening       = (fill == '0);
  assign push_last_idx = (c.op == OP_APPEND) ? APPEND_LAST_IDX : HEADER_LAST_IDX;

  // Byte k of the current op; header bytes are big-endian
  always_comb begin
    case (k)
      3'd0:    push_val = (c.op == OP_APPEND) ? c.data_byte : MARK_HEADER;
      3'd1:    push_val = MARK_HEADER;
      3'd2:    push_val = c.message_id[15:8];
      3'd3:    push_val = c.message_id[7:0];
      3'd4:    push_val = c.message_length[31:24];
      3'd5:    push_val = c.message_length[23:16];
      3'd6:    push_val = c.message_length[15:8];
      default: push_val = c.message_length[7:0];
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd.op)
            OP_APPEND, OP_HEADER: state_next = ST_PUSH;
            OP_PAD:   state_next = opening ? ST_IDLE : ST_PAD;
            OP_READ:  state_next = (read_slot == write_slot) ? ST_IDLE : ST_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_PUSH:  if (!opening && k == push_last_idx) state_next = ST_IDLE;
      ST_PAD:   if (fill == POS_LAST) state_next = ST_IDLE;
      ST_RD:    if (rpos == POS_LAST) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Store port drive
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_addr(write_slot, opening ? '0 : fill);
    mem_wdata = 8'h00;
    mem_re    = 1'b0;
    mem_raddr = mem_addr(read_slot, rpos);
    unique case (state)
      ST_PUSH: begin
        mem_we    = 1'b1;
        mem_wdata = opening ? MARK_START : push_val;
      end
      ST_PAD: begin
        mem_we = 1'b1;
      end
      ST_RD: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      c <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      k          <= '0;
      fill       <= '0;
      rpos       <= '0;
      read_slot  <= '0;
      write_slot <= '0;
      drops      <= '0;
      rd_pend    <= 1'b0;
      rd_last    <= 1'b0;
      empty_pend <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pend    <= (state == ST_RD);
      rd_last    <= (state == ST_RD) && (rpos == POS_LAST);
      empty_pend <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            k    <= '0;
            rpos <= '0;
            if (cmd.op == OP_READ && read_slot == write_slot) begin
              empty_pend <= 1'b1;
            end
          end
        end
        ST_PUSH: begin
          if (opening) begin
            // new packet: '?' goes in this cycle, drop oldest if ring is full
            fill <= POS_W'(1);
            if (next_slot(write_slot) == read_slot) begin
              read_slot <= next_slot(read_slot);
              drops     <= drops + 32'd1;
            end
          end else begin
            k <= k + 3'd1;
            if (fill == POS_LAST) begin
              fill       <= '0;
              write_slot <= next_slot(write_slot);
            end else begin
              fill <= fill + 1'b1;
            end
          end
        end
        ST_PAD: begin
          if (fill == POS_LAST) begin
            fill       <= '0;
            write_slot <= next_slot(write_slot);
          end else begin
            fill <= fill + 1'b1;
          end
        end
        ST_RD: begin
          rpos <= rpos + 1'b1;
          if (rpos == POS_LAST) begin
            read_slot <= next_slot(read_slot);
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  assign busy              = (state != ST_IDLE);
  assign status.rd_pend    = rd_pend;
  assign status.rd_last    = rd_last;
  assign status.empty_pend = empty_pend;
  assign status.drops      = drops;

  `UPTQ_ASSERT_NEXT(a_rd_data_follows, state == ST_RD, rd_pend, "read issue without data")
  `UPTQ_ASSERT_ALWAYS(a_no_dual_result, !(rd_pend && empty_pend), "packet and empty overlap")
  `UPTQ_ASSERT_ALWAYS(a_no_write_in_read, !(mem_we && mem_re), "store written during read")
  `UPTQ_ASSERT_NEXT(a_last_ends_read, rd_last, state == ST_IDLE, "last byte not at read end")
  `UPTQ_ASSERT_NEXT(a_pad_open, state == ST_PAD && fill != POS_LAST, fill != '0,
                    "pad lost open packet")

endmodule

/* rtl/core/usb_packet_tx_queue_core.sv */
// Top level of the packetizing transmit queue with drop-oldest overflow.
// Depends on uptq_pkg, uptq_ctrl and uptq_ram.
`timescale 1ns / 1ps

// Channel   Ports                 Transaction taken when
// -------   -------------------   ------------------------------
// command   start, busy, cmd      rising edge with start=1, busy=0
// result    res_valid, res        every edge ending a res_valid cycle
//
// Busy: an append that opens a packet writes the '?' mark first, a
// header pushes eight bytes, a pad fills out the open packet, a read
// streams a packet; an empty read or pad with nothing open stays idle.
// Read timing is set by the one read port of the packet store: one byte a
// cycle, data in the cycle after its address.
// Reset (rst, synchronous) empties the ring and clears the drop count; the
// store is not cleared, since a closed packet is always fully written.
// The receiver cannot stall: each result shows for exactly one cycle.

module usb_packet_tx_queue_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  uptq_pkg::cmd_t cmd,
  output logic           busy,
  output logic           res_valid,
  output uptq_pkg::res_t res
);

  import uptq_pkg::*;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  rd_status_t        status;

  // Sequencer: runs each command as a series of store writes or reads
  uptq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .status    (status)
  );

  // Packet store: SLOT_COUNT slots of PACKET_BYTES bytes
  uptq_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result stage: all sources are registers, so this is only a select
  assign res_valid      = status.rd_pend | status.empty_pend;
  assign res.out_byte   = status.empty_pend ? 8'h00 : mem_rdata;
  assign res.last       = status.empty_pend | status.rd_last;
  assign res.empty_res  = status.empty_pend;
  assign res.drop_count = status.drops;

endmodule

/* verif/tb.sv */
// Testbench for usb_packet_tx_queue_core: directed and random command traffic
// checked byte by byte against an in-bench model of the packet ring.
// Depends on uptq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import uptq_pkg::*;

  // Clock, reset and DUT ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic res_valid;
  res_t res;

  always #5 clk = ~clk;

  usb_packet_tx_queue_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  // Commands waiting to be driven, and packet bytes the model says must come out
  cmd_t pending_cmds[$];
  res_t expected_tx_bytes[$];

  // Ring model: byte store, oldest closed slot, open slot, fill position, drops
  logic [7:0]  ring_mem [STORE_BYTES];
  int unsigned ring_rd_slot = 0;
  int unsigned ring_wr_slot = 0;
  int unsigned ring_fill = 0;
  logic [31:0] ring_drops = '0;

  // Run statistics
  int errors = 0;
  int cmds_accepted = 0;
  int packets_read = 0;
  int empty_reads = 0;
  int bytes_checked = 0;

  // Sender burst/gap shaping
  int burst_left = 0;
  int gap_left = 0;

  function automatic int unsigned slot_after(input int unsigned s);
    return (s + 1) % SLOT_COUNT;
  endfunction

  // One byte into the open packet; opening a packet on a full ring drops the
  // oldest closed one. A packet closes on its own once it is full.
  task automatic ring_push(input logic [7:0] b);
    if (ring_fill == 0) begin
      if (slot_after(ring_wr_slot) == ring_rd_slot) begin
        ring_drops++;
        ring_rd_slot = slot_after(ring_rd_slot);
      end
      ring_mem[ring_wr_slot * PACKET_BYTES] = MARK_START;
      ring_fill = 1;
    end
    ring_mem[ring_wr_slot * PACKET_BYTES + ring_fill] = b;
    ring_fill++;
    if (ring_fill >= PACKET_BYTES) begin
      ring_fill = 0;
      ring_wr_slot = slot_after(ring_wr_slot);
    end
  endtask

  // Apply one accepted transaction to the model, queue any bytes it will emit
  task automatic ring_apply(input cmd_t c);
    res_t r;
    case (c.op)
      OP_APPEND: ring_push(c.data_byte);
      OP_HEADER: begin
        ring_push(MARK_HEADER);
        ring_push(MARK_HEADER);
        ring_push(c.message_id[15:8]);
        ring_push(c.message_id[7:0]);
        ring_push(c.message_length[31:24]);
        ring_push(c.message_length[23:16]);
        ring_push(c.message_length[15:8]);
        ring_push(c.message_length[7:0]);
      end
      OP_PAD: begin
        // pad with nothing open is a no-op
        if (ring_fill != 0) begin
          while (ring_fill < PACKET_BYTES) begin
            ring_mem[ring_wr_slot * PACKET_BYTES + ring_fill] = 8'h00;
            ring_fill++;
          end
          ring_fill = 0;
          ring_wr_slot = slot_after(ring_wr_slot);
        end
      end
      OP_READ: begin
        if (ring_rd_slot == ring_wr_slot) begin
          // nothing closed: single empty marker, open packet stays put
          r.out_byte = 8'h00;
          r.last = 1'b1;
          r.empty_res = 1'b1;
          r.drop_count = ring_drops;
          expected_tx_bytes.push_back(r);
          empty_reads++;
        end else begin
          for (int i = 0; i < PACKET_BYTES; i++) begin
            r.out_byte = ring_mem[ring_rd_slot * PACKET_BYTES + i];
            r.last = (i == PACKET_BYTES - 1);
            r.empty_res = 1'b0;
            r.drop_count = ring_drops;
            expected_tx_bytes.push_back(r);
          end
          ring_rd_slot = slot_after(ring_rd_slot);
          packets_read++;
        end
      end
    endcase
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic cmd_t make_cmd(input op_t o, input logic [7:0] d,
                                    input logic [15:0] id, input logic [31:0] len);
    cmd_t c;
    c.op = o;
    c.data_byte = d;
    c.message_id = id;
    c.message_length = len;
    return c;
  endfunction

  // Random content, with the all-zero and all-one extremes showing up often
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random command shaped by phase:
  //   0 mixed, 1 write heavy with no reads (fills the ring, forces drops),
  //   2 read heavy (drains, hits empty reads), 3 append heavy (packets close full)
  function automatic cmd_t rand_cmd(input int phase);
    int pick;
    op_t o;
    logic [31:0] w;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    case (phase)
      0: o = (pick < 40) ? OP_APPEND : (pick < 60) ? OP_HEADER :
             (pick < 80) ? OP_PAD : OP_READ;
      1: o = (pick < 40) ? OP_APPEND : (pick < 70) ? OP_HEADER : OP_PAD;
      2: o = (pick < 20) ? OP_APPEND : (pick < 30) ? OP_HEADER :
             (pick < 40) ? OP_PAD : OP_READ;
      default: o = (pick < 85) ? OP_APPEND : (pick < 95) ? OP_READ : OP_PAD;
    endcase
    w = rand_word();
    v = rand_word();
    return make_cmd(o, w[7:0], v[31:16], rand_word());
  endfunction

  // Driver: present queued commands in bursts with random gaps. A transaction
  // is taken at an edge with start=1 and busy=0; start never drops while a
  // command is still waiting to be taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        ring_apply(cmd);
        cmds_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd <= pending_cmds.pop_front();
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            // about a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every res_valid cycle is one transaction; the receiver has no
  // way to stall, so each strobe is checked against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid) begin
      if (expected_tx_bytes.size() == 0) begin
        flag_error($sformatf("unexpected result byte=%02h last=%0b empty=%0b drops=%0d",
                             res.out_byte, res.last, res.empty_res, res.drop_count));
      end else begin
        want = expected_tx_bytes.pop_front();
        if (res.out_byte !== want.out_byte || res.last !== want.last ||
            res.empty_res !== want.empty_res || res.drop_count !== want.drop_count)
          flag_error($sformatf({"result mismatch: exp byte=%02h last=%0b empty=%0b ",
                                "drops=%0d, got byte=%02h last=%0b empty=%0b drops=%0d"},
                               want.out_byte, want.last, want.empty_res, want.drop_count,
                               res.out_byte, res.last, res.empty_res, res.drop_count));
      end
      bytes_checked++;
    end
  end

  // Stimulus and end of run
  initial begin
    // Directed: empty ring, no-op pad, byte extremes, header extremes,
    // pad-close, a packet that closes by filling up, and an open packet that
    // must not be readable.
    pending_cmds.push_back(make_cmd(OP_READ, 8'h00, 16'h0000, 32'h0));
    pending_cmds.push_back(make_cmd(OP_PAD, 8'h00, 16'h0000, 32'h0));
    pending_cmds.push_back(make_cmd(OP_APPEND, 8'h00, 16'h0000, 32'h0));
    pending_cmds.push_back(make_cmd(OP_APPEND, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(OP_HEADER, 8'h00, 16'hFFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(OP_HEADER, 8'hFF, 16'h0000, 32'h0000_0000));
    pending_cmds.push_back(make_cmd(OP_PAD, 8'h00, 16'h0000, 32'h0));
    pending_cmds.push_back(make_cmd(OP_READ, 8'h00, 16'h0000, 32'h0));
    pending_cmds.push_back(make_cmd(OP_READ, 8'h00, 16'h0000, 32'h0));
    // 7 headers + 7 appends = 63 payload bytes: packet closes without a pad
    for (int i = 0; i < 7; i++)
      pending_cmds.push_back(make_cmd(OP_HEADER, 8'h00, 16'(16'h1234 + i), 32'h89AB_CDEF));
    for (int i = 0; i < 7; i++)
      pending_cmds.push_back(make_cmd(OP_APPEND, 8'(8'hA0 + i), 16'h0, 32'h0));
    pending_cmds.push_back(make_cmd(OP_HEADER, 8'h00, 16'h5A5A, 32'h0102_0304));
    pending_cmds.push_back(make_cmd(OP_READ, 8'h00, 16'h0000, 32'h0));
    pending_cmds.push_back(make_cmd(OP_READ, 8'h00, 16'h0000, 32'h0));

    // Random: phases of 40 commands cycling through the traffic mixes
    for (int i = 0; i < 320; i++)
      pending_cmds.push_back(rand_cmd((i / 40) % 4));
    // flush whatever is left so the tail of the run drains the ring
    pending_cmds.push_back(make_cmd(OP_PAD, 8'h00, 16'h0000, 32'h0));
    for (int i = 0; i < SLOT_COUNT + 1; i++)
      pending_cmds.push_back(make_cmd(OP_READ, 8'h00, 16'h0000, 32'h0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // all commands taken, then every expected byte seen, then a quiet tail
    // long enough for a stray packet to show up
    @(posedge clk);
    while (pending_cmds.size() > 0 || start) @(posedge clk);
    while (expected_tx_bytes.size() > 0) @(posedge clk);
    repeat (PACKET_BYTES + 8) @(posedge clk);

    $display("Covered %0d commands: %0d packets read, %0d empty reads, %0d bytes checked.",
             cmds_accepted, packets_read, empty_reads, bytes_checked);
    $display("Model drop counter finished at %0d; %0d errors.", ring_drops, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Timeout with %0d results still expected.", expected_tx_bytes.size());
    $display("simulation failed");
    $finish;
  end

endmodule
